// File: design/vtpg_pkg.sv
// Shared types, constants and colour tables of the video test pattern generator.
`default_nettype none

package vtpg_pkg;

  localparam int DIM_BITS    = 12;
  localparam int BAR_COUNT   = 8;
  localparam int BAR_SHIFT   = $clog2(BAR_COUNT);
  localparam int SQUARE_SIZE = 16;
  localparam int SQ_SHIFT    = $clog2(SQUARE_SIZE);
  localparam int TOTAL_W     = 26;
  localparam int PAYLOAD_W   = 25;
  localparam int CFG_DATA_W  = DIM_BITS;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

  localparam int DESC_DEPTH  = 2;
  localparam int DESC_PTR_W  = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
  localparam int DESC_CNT_W  = $clog2(DESC_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_PTR_W   = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0]  LUMA_HI    = 8'd235;
  localparam logic [7:0]  LUMA_LO    = 8'd16;
  localparam logic [7:0]  CHROMA_MID = 8'd128;
  localparam logic [15:0] RGB_WHITE  = 16'hFFFF;
  localparam logic [15:0] RGB_BLACK  = 16'h0000;

  localparam logic [7:0] BAR_LUMA [BAR_COUNT] = '{
    8'd255, 8'd226, 8'd179, 8'd150, 8'd105, 8'd76, 8'd29, 8'd0};
  localparam logic [7:0] BAR_CB [BAR_COUNT] = '{
    8'd128, 8'd0, 8'd170, 8'd43, 8'd212, 8'd84, 8'd255, 8'd128};
  localparam logic [7:0] BAR_CR [BAR_COUNT] = '{
    8'd128, 8'd149, 8'd0, 8'd21, 8'd234, 8'd255, 8'd107, 8'd128};
  localparam logic [15:0] BAR_RGB [BAR_COUNT] = '{
    16'hFFFF, 16'hFFE0, 16'h07FF, 16'h07E0, 16'hF81F, 16'hF800, 16'h001F, 16'h0000};

  typedef enum logic [1:0] {
    REG_PATTERN = 2'd0,
    REG_FORMAT  = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FMT_YVYU   = 3'd0,
    FMT_YUYV   = 3'd1,
    FMT_RGB565 = 3'd2,
    FMT_GREY   = 3'd3
  } pix_fmt_e;

  // one classified pixel request, front to back
  typedef struct packed {
    logic                     err;
    logic [2:0]               fmt;
    logic                     board;
    logic                     white;
    logic [BAR_SHIFT-1:0]     bar;
    logic                     odd;
    logic                     last;
    logic [PAYLOAD_W-1:0]     payload;
  } desc_t;

  typedef struct packed {
    logic [7:0]           first_byte;
    logic [7:0]           second_byte;
    logic [1:0]           byte_count;
    logic                 end_of_frame;
    logic [PAYLOAD_W-1:0] payload_bytes;
    logic                 error;
  } result_t;

endpackage

`default_nettype wire

// File: design/vtpg_front.sv
// Front end: config registers, raster position tracking and pixel classification.
`default_nettype none

module vtpg_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire vtpg_pkg::cfg_reg_e          cfg_idx_i,
  input  wire logic [vtpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        restart_i,
  input  wire logic                        desc_full_i,
  output logic                             desc_push_o,
  output vtpg_pkg::desc_t                  desc_o
);
  import vtpg_pkg::*;

  logic                pattern_q;
  logic [2:0]          fmt_q;
  logic [DIM_BITS-1:0] width_q, height_q;

  logic [DIM_BITS-1:0]  col_q, col_d, row_q, row_d, pos_q, pos_d;
  logic [BAR_SHIFT-1:0] bar_q, bar_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  logic                 accept, cfg_err, home, last, line_end, bar_end;
  logic [DIM_BITS-1:0]  eff_col, eff_row, eff_pos, bar_width;
  logic [BAR_SHIFT-1:0] eff_bar;
  logic [TOTAL_W-1:0]   eff_total, total_sum;
  logic [1:0]           cnt;
  logic [DIM_BITS:0]    col_inc, pos_inc;

  assign full        = desc_full_i;
  assign accept      = push & ~desc_full_i;
  assign desc_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= 1'b0;
      fmt_q     <= FMT_YUYV;
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATTERN: pattern_q <= cfg_data_i[0];
        REG_FORMAT:  fmt_q     <= cfg_data_i[2:0];
        REG_WIDTH:   width_q   <= cfg_data_i[DIM_BITS-1:0];
        REG_HEIGHT:  height_q  <= cfg_data_i[DIM_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    cfg_err = (width_q == '0) || (height_q == '0) || fmt_q[2] ||
              (!pattern_q && (width_q < DIM_BITS'(BAR_COUNT)));
    // out-of-frame position after a size change behaves like a restart
    home      = restart_i || (col_q >= width_q) || (row_q >= height_q);
    eff_col   = home ? '0 : col_q;
    eff_row   = home ? '0 : row_q;
    eff_pos   = home ? '0 : pos_q;
    eff_bar   = home ? '0 : bar_q;
    eff_total = home ? '0 : total_q;

    cnt       = (fmt_q == FMT_GREY) ? 2'd1 : 2'd2;
    total_sum = eff_total + TOTAL_W'(cnt);
    last      = (eff_col == width_q - 1'b1) && (eff_row == height_q - 1'b1);

    bar_width = width_q >> BAR_SHIFT;
    col_inc   = {1'b0, eff_col} + 1'b1;
    pos_inc   = {1'b0, eff_pos} + 1'b1;
    line_end  = col_inc >= {1'b0, width_q};
    bar_end   = pos_inc >= {1'b0, bar_width};
  end

  always_comb begin
    col_d   = '0;
    row_d   = '0;
    pos_d   = '0;
    bar_d   = '0;
    total_d = '0;
    if (!(cfg_err || last)) begin
      total_d = total_sum;
      if (line_end) begin
        row_d = eff_row + 1'b1;
      end else begin
        row_d = eff_row;
        col_d = col_inc[DIM_BITS-1:0];
        if (bar_end) begin
          bar_d = (eff_bar < BAR_SHIFT'(BAR_COUNT - 1)) ? eff_bar + 1'b1 : eff_bar;
        end else begin
          bar_d = eff_bar;
          pos_d = pos_inc[DIM_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      pos_q   <= '0;
      bar_q   <= '0;
      total_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      pos_q   <= pos_d;
      bar_q   <= bar_d;
      total_q <= total_d;
    end
  end

  always_comb begin
    desc_o.err     = cfg_err;
    desc_o.fmt     = fmt_q;
    desc_o.board   = pattern_q;
    desc_o.white   = eff_col[SQ_SHIFT] == eff_row[SQ_SHIFT];
    desc_o.bar     = eff_bar;
    desc_o.odd     = eff_col[0];
    desc_o.last    = last;
    desc_o.payload = total_sum[PAYLOAD_W-1:0];
  end

endmodule

`default_nettype wire

// File: design/vtpg_desc_fifo.sv
// Short queue of classified pixel requests between front and back.
`default_nettype none

module vtpg_desc_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire vtpg_pkg::desc_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output vtpg_pkg::desc_t      data_o,
  output logic                 empty_o
);
  import vtpg_pkg::*;

  desc_t                 mem_q [DESC_DEPTH];
  logic [DESC_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [DESC_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = cnt_q == DESC_CNT_W'(DESC_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) wr_d = (wr_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == DESC_PTR_W'(DESC_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + DESC_CNT_W'(do_push) - DESC_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: design/vtpg_back.sv
// Back end: colour lookup, byte packing and the output result queue.
`default_nettype none

module vtpg_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire vtpg_pkg::desc_t  desc_i,
  input  wire logic             desc_empty_i,
  output logic                  desc_pop_o,
  output logic                  empty,
  input  wire logic             pop,
  output vtpg_pkg::result_t     res_o
);
  import vtpg_pkg::*;

  result_t              res_q [OUT_DEPTH];
  result_t              res_d;
  logic [OUT_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;
  logic [7:0]           luma, cb, cr;
  logic [15:0]          rgb;

  assign empty      = cnt_q == '0;
  assign do_pop     = pop & ~empty;
  assign do_push    = ~desc_empty_i & (cnt_q != OUT_CNT_W'(OUT_DEPTH));
  assign desc_pop_o = do_push;
  assign res_o      = res_q[rd_q];

  always_comb begin
    if (desc_i.board) begin
      luma = desc_i.white ? LUMA_HI : LUMA_LO;
      cb   = CHROMA_MID;
      cr   = CHROMA_MID;
      rgb  = desc_i.white ? RGB_WHITE : RGB_BLACK;
    end else begin
      luma = BAR_LUMA[desc_i.bar];
      cb   = BAR_CB[desc_i.bar];
      cr   = BAR_CR[desc_i.bar];
      rgb  = BAR_RGB[desc_i.bar];
    end
  end

  always_comb begin
    res_d = '0;
    if (desc_i.err) begin
      res_d.end_of_frame = 1'b1;
      res_d.error        = 1'b1;
    end else begin
      unique case (desc_i.fmt)
        FMT_YVYU: begin
          res_d.first_byte  = luma;
          res_d.second_byte = desc_i.odd ? cb : cr;
          res_d.byte_count  = 2'd2;
        end
        FMT_YUYV: begin
          res_d.first_byte  = luma;
          res_d.second_byte = desc_i.odd ? cr : cb;
          res_d.byte_count  = 2'd2;
        end
        FMT_RGB565: begin
          res_d.first_byte  = rgb[7:0];
          res_d.second_byte = rgb[15:8];
          res_d.byte_count  = 2'd2;
        end
        default: begin
          res_d.first_byte  = luma;
          res_d.byte_count  = 2'd1;
        end
      endcase
      res_d.end_of_frame  = desc_i.last;
      res_d.payload_bytes = desc_i.last ? desc_i.payload : '0;
    end
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (do_push) wr_d = (wr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + OUT_CNT_W'(do_push) - OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) res_q[wr_q] <= res_d;
  end

endmodule

`default_nettype wire

// File: design/video_test_pattern_generator.sv
// Top level of the video test pattern generator.
//
//  channel  | handshake              | carries
//  ---------+------------------------+------------------------------------------
//  input    | push / full            | restart_i
//  result   | empty / pop            | first/second byte, count, eof, total, err
//  config   | cfg_we_i (no wait)     | cfg_idx_i, cfg_data_i
//
// One pixel request per clock sustained while full is low; the front's position update
// is combinational. A request goes through the request queue, then the result queue.
// Reset clears position, byte total and both queues; config returns to its reset values.
// full rises when the two-entry request queue is full; the back end stops draining it
// while its two-entry result queue is full and waits on pop.
`default_nettype none

module video_test_pattern_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire vtpg_pkg::cfg_reg_e                cfg_idx_i,
  input  wire logic [vtpg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              restart_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [7:0]                             first_byte_o,
  output logic [7:0]                             second_byte_o,
  output logic [1:0]                             byte_count_o,
  output logic                                   end_of_frame_o,
  output logic [vtpg_pkg::PAYLOAD_W-1:0]         payload_bytes_o,
  output logic                                   error_o
);
  import vtpg_pkg::*;

  desc_t   front_desc, back_desc;
  logic    desc_push, desc_full, desc_pop, desc_empty;
  result_t res;

  vtpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .restart_i   (restart_i),
    .desc_full_i (desc_full),
    .desc_push_o (desc_push),
    .desc_o      (front_desc)
  );

  vtpg_desc_fifo u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .data_i  (front_desc),
    .full_o  (desc_full),
    .pop_i   (desc_pop),
    .data_o  (back_desc),
    .empty_o (desc_empty)
  );

  vtpg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (back_desc),
    .desc_empty_i (desc_empty),
    .desc_pop_o   (desc_pop),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign first_byte_o    = res.first_byte;
  assign second_byte_o   = res.second_byte;
  assign byte_count_o    = res.byte_count;
  assign end_of_frame_o  = res.end_of_frame;
  assign payload_bytes_o = res.payload_bytes;
  assign error_o         = res.error;

endmodule

`default_nettype wire

// File: design/vtpg_checker.sv
// Port-level checks on the video test pattern generator, bound to the top level.
`default_nettype none

module vtpg_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire logic [7:0]                      second_byte_o,
  input wire logic [1:0]                      byte_count_o,
  input wire logic                            end_of_frame_o,
  input wire logic [vtpg_pkg::PAYLOAD_W-1:0]  payload_bytes_o,
  input wire logic                            error_o
);
  import vtpg_pkg::*;

  // an errored pixel closes the frame and carries no bytes
  a_err_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (end_of_frame_o && byte_count_o == 2'd0 &&
                              payload_bytes_o == '0))
    else $error("error result not closed cleanly");

  a_total_only_at_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !end_of_frame_o) |-> (payload_bytes_o == '0))
    else $error("byte total outside end of frame");

  // a non-error result carries two bytes, or a single byte with the second byte zero
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !error_o) |-> (byte_count_o == 2'd2 ||
                              (byte_count_o == 2'd1 && second_byte_o == 8'd0)))
    else $error("bad byte count");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

endmodule

bind video_test_pattern_generator vtpg_checker u_vtpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .second_byte_o   (second_byte_o),
  .byte_count_o    (byte_count_o),
  .end_of_frame_o  (end_of_frame_o),
  .payload_bytes_o (payload_bytes_o),
  .error_o         (error_o)
);

`default_nettype wire
